/* design/smie_pkg.sv */
package smie_pkg;

    // Storage depths
    localparam int STACK_DEPTH = 2048;
    localparam int PROG_DEPTH  = 2048;
    localparam int STORE_DEPTH = 512;
    localparam int CALL_DEPTH  = 512;

    // Derived widths
    localparam int SP_W   = $clog2(STACK_DEPTH);
    localparam int PC_W   = $clog2(PROG_DEPTH);
    localparam int ST_W   = $clog2(STORE_DEPTH);
    localparam int CI_W   = $clog2(CALL_DEPTH);
    localparam int RP_W   = $clog2(CALL_DEPTH + 1);
    localparam int RA_W   = PC_W + 1;
    localparam int DATA_W = 32;
    localparam int OP_W   = 5;
    localparam int CH_W   = 9;
    localparam int PK_W   = 2;
    localparam int ERR_W  = 4;

    // Newline typed in is pushed as the null character
    localparam logic [CH_W-1:0]   CH_NEWLINE = CH_W'(10);
    localparam logic [DATA_W-1:0] CH_NULL    = '0;

    typedef enum logic [OP_W-1:0] {
        OP_NOP    = 5'd0,
        OP_PUSH   = 5'd1,
        OP_LOAD   = 5'd2,
        OP_STORE  = 5'd3,
        OP_J      = 5'd4,
        OP_CALL   = 5'd5,
        OP_JZ     = 5'd6,
        OP_JLEZ   = 5'd7,
        OP_JNZ    = 5'd8,
        OP_RET    = 5'd9,
        OP_POPC   = 5'd10,
        OP_ADD    = 5'd11,
        OP_SUB    = 5'd12,
        OP_MUL    = 5'd13,
        OP_DIV    = 5'd14,
        OP_MOD    = 5'd15,
        OP_EQ     = 5'd16,
        OP_NE     = 5'd17,
        OP_LT     = 5'd18,
        OP_LE     = 5'd19,
        OP_GT     = 5'd20,
        OP_GE     = 5'd21,
        OP_PRINTI = 5'd22,
        OP_PRINTC = 5'd23,
        OP_READC  = 5'd24,
        OP_POP    = 5'd25,
        OP_HALT   = 5'd26
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 4'd0,
        ERR_BAD_OP     = 4'd1,
        ERR_STK_OVER   = 4'd2,
        ERR_STK_UNDER  = 4'd3,
        ERR_CALL_OVER  = 4'd4,
        ERR_CALL_UNDER = 4'd5,
        ERR_DIV_ZERO   = 4'd6,
        ERR_ADDR       = 4'd7,
        ERR_PC         = 4'd8
    } t_err;

    typedef enum logic [PK_W-1:0] {
        PK_NONE = 2'd0,
        PK_INT  = 2'd1,
        PK_CHAR = 2'd2
    } t_print;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_COMMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
        logic [DATA_W-1:0] rem;
    } t_div_out;

endpackage

/* design/smie_divider.sv */
module smie_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [smie_pkg::DATA_W-1:0]  i_dividend,
    input  logic signed [smie_pkg::DATA_W-1:0]  i_divisor,
    output smie_pkg::t_div_out                  o_div
);
    import smie_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg_q;
    logic              r_neg_r;

    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;

    // Shift in one dividend bit and trial-subtract the divisor
    assign w_shift = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    // Control: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DATA_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath on magnitudes; signs fixed at the output
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo   <= i_dividend[DATA_W-1] ? -i_dividend : i_dividend;
            r_den   <= i_divisor[DATA_W-1] ? -i_divisor : i_divisor;
            r_rem   <= '0;
            r_neg_q <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            r_neg_r <= i_dividend[DATA_W-1];
        end else if (r_busy) begin
            if (!w_diff[DATA_W]) begin
                r_rem <= w_diff;
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_div.done = r_done;
    assign o_div.quot = r_neg_q ? -r_quo : r_quo;
    assign o_div.rem  = r_neg_r ? -r_rem[DATA_W-1:0] : r_rem[DATA_W-1:0];

endmodule

/* design/stack_machine_instruction_execute.sv */
// Executes one instruction of a 32-bit stack machine per item and returns one
// result per item. An ordinary item is accepted in S_IDLE, which reads the data
// stack (top and next), the data store and the return stack from synchronous
// memories, and is executed and written back in S_EXEC. DIV and MOD run through
// a one-bit-per-cycle divider in state S_DIV. A finished result waits in an
// output register, so the next item is taken while it is still stalled,
// unless a second result is already waiting. After reset the block clears the
// 512-entry data store, one entry a cycle, and stalls its input until the clear
// is done. Once halt or an error is set, items execute nothing until reset.
module stack_machine_instruction_execute (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [smie_pkg::OP_W-1:0]           i_action,
    input  logic signed [smie_pkg::DATA_W-1:0]  i_operand,
    input  logic signed [smie_pkg::CH_W-1:0]    i_read_char,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [smie_pkg::PC_W-1:0]           o_next_pc,
    output logic signed [smie_pkg::DATA_W-1:0]  o_top_value,
    output logic [smie_pkg::PK_W-1:0]           o_print_kind,
    output logic                                o_halted,
    output logic [smie_pkg::ERR_W-1:0]          o_error_code,
    output logic [smie_pkg::SP_W-1:0]           o_stack_level
);
    import smie_pkg::*;

    // Memories
    logic [DATA_W-1:0] mem_stack [STACK_DEPTH];
    logic [DATA_W-1:0] mem_store [STORE_DEPTH];
    logic [RA_W-1:0]   mem_ret   [CALL_DEPTH];

    // Control state
    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [RP_W-1:0] r_rp, n_rp;
    logic            r_halt, n_halt;
    t_err            r_err, n_err;
    logic [SP_W-1:0] r_hwm, n_hwm;
    logic            r_w0, n_w0;
    logic [ST_W-1:0] r_clr;

    // Item and read data
    t_op               r_op;
    logic [DATA_W-1:0] r_word;
    logic [CH_W-1:0]   r_rc;
    logic [DATA_W-1:0] r_rd_a, r_rd_b, r_rd_st;
    logic [RA_W-1:0]   r_rd_ret;
    logic              r_a_ok, r_b_ok;

    // Output and pending result
    logic              r_o_valid;
    logic [PC_W-1:0]   r_o_pc;
    logic [DATA_W-1:0] r_o_top;
    t_print            r_o_pk;
    logic              r_o_halt;
    t_err              r_o_err;
    logic [SP_W-1:0]   r_o_sp;
    logic [DATA_W-1:0] r_p_top;
    t_print            r_p_pk;

    logic              w_acc;
    logic [SP_W-1:0]   w_sp_m1;
    logic [CI_W-1:0]   w_ret_ra;
    logic [DATA_W-1:0] w_a, w_b;
    logic              w_live;
    logic              w_div_go;
    logic              w_commit;
    t_div_out          w_div;

    logic              w_st_we;
    logic [SP_W-1:0]   w_st_idx;
    logic [DATA_W-1:0] w_st_val;
    logic              w_sw_we;
    logic [ST_W-1:0]   w_sw_idx;
    logic [DATA_W-1:0] w_sw_val;
    logic              w_cw_we;
    logic [DATA_W-1:0] w_res_top;
    t_print            w_res_pk;
    logic              w_o_load;

    assign o_stall  = (r_state != S_IDLE);
    assign w_acc    = i_valid && !o_stall;
    assign w_sp_m1  = r_sp - 1'b1;
    assign w_ret_ra = CI_W'(r_rp - 1'b1);
    assign w_live   = !r_halt && (r_err == ERR_NONE);

    // Entries never written read as zero
    assign w_a = r_a_ok ? r_rd_a : '0;
    assign w_b = r_b_ok ? r_rd_b : '0;

    assign w_div_go = (r_state == S_EXEC) && w_live && (r_op == OP_DIV || r_op == OP_MOD)
                      && (r_sp != '0) && (w_b != '0);
    assign w_commit = ((r_state == S_EXEC) && !w_div_go) || (r_state == S_COMMIT);

    smie_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_go),
        .i_dividend (w_a),
        .i_divisor  (w_b),
        .o_div      (w_div)
    );

    // Read memories when an item is accepted
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op     <= t_op'(i_action);
            r_word   <= i_operand;
            r_rc     <= i_read_char;
            r_rd_a   <= mem_stack[r_sp];
            r_rd_b   <= mem_stack[w_sp_m1];
            r_rd_st  <= mem_store[i_operand[ST_W-1:0]];
            r_rd_ret <= mem_ret[w_ret_ra];
            r_a_ok   <= (r_sp <= r_hwm) && ((r_sp != '0) || r_w0);
            r_b_ok   <= (w_sp_m1 <= r_hwm) && ((w_sp_m1 != '0) || r_w0);
        end
    end

    // Write back
    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            mem_stack[w_st_idx] <= w_st_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem_store[r_clr] <= '0;
        end else if (w_sw_we) begin
            mem_store[w_sw_idx] <= w_sw_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cw_we) begin
            mem_ret[r_rp[CI_W-1:0]] <= RA_W'(r_pc) + RA_W'(2);
        end
    end

    // Execute: next state, write-back and result
    always_comb begin
        logic [DATA_W:0]   npc;
        logic [DATA_W:0]   target;
        logic [DATA_W-1:0] alu;
        logic [DATA_W-1:0] rc_ext;
        t_err              e;
        t_print            pk;
        logic              halt;
        logic              st_we;
        logic [SP_W-1:0]   st_idx;
        logic [DATA_W-1:0] st_val;
        logic              sw_we;
        logic              cw_we;
        logic [SP_W-1:0]   sp_new;
        logic [RP_W-1:0]   rp_new;
        logic [DATA_W-1:0] top;
        logic              addr_bad;
        logic              take;

        target   = {r_word[DATA_W-1], r_word};
        npc      = (DATA_W+1)'(r_pc) + (DATA_W+1)'(1);
        e        = ERR_NONE;
        pk       = PK_NONE;
        halt     = 1'b0;
        st_we    = 1'b0;
        st_idx   = r_sp + 1'b1;
        st_val   = '0;
        sw_we    = 1'b0;
        cw_we    = 1'b0;
        sp_new   = r_sp;
        rp_new   = r_rp;
        top      = w_a;
        addr_bad = r_word[DATA_W-1:ST_W] != '0;
        take     = 1'b0;
        rc_ext   = (r_rc == CH_NEWLINE) ? CH_NULL : {{(DATA_W-CH_W){r_rc[CH_W-1]}}, r_rc};

        // ALU result for binary operations
        case (r_op)
            OP_ADD:  alu = w_a + w_b;
            OP_SUB:  alu = w_a - w_b;
            OP_MUL:  alu = w_a * w_b;
            OP_DIV:  alu = w_div.quot;
            OP_MOD:  alu = w_div.rem;
            OP_EQ:   alu = DATA_W'(w_a == w_b);
            OP_NE:   alu = DATA_W'(w_a != w_b);
            OP_LT:   alu = DATA_W'($signed(w_a) < $signed(w_b));
            OP_LE:   alu = DATA_W'($signed(w_a) <= $signed(w_b));
            OP_GT:   alu = DATA_W'($signed(w_a) > $signed(w_b));
            OP_GE:   alu = DATA_W'($signed(w_a) >= $signed(w_b));
            default: alu = '0;
        endcase

        case (r_op)
            OP_NOP: begin
            end
            OP_PUSH, OP_LOAD, OP_READC: begin
                if (r_sp == SP_W'(STACK_DEPTH - 1)) begin
                    e = ERR_STK_OVER;
                end else if (r_op == OP_LOAD && addr_bad) begin
                    e = ERR_ADDR;
                end else begin
                    st_we  = 1'b1;
                    sp_new = r_sp + 1'b1;
                    case (r_op)
                        OP_PUSH: st_val = r_word;
                        OP_LOAD: st_val = r_rd_st;
                        default: st_val = rc_ext;
                    endcase
                    top = st_val;
                    if (r_op != OP_READC) begin
                        npc = (DATA_W+1)'(r_pc) + (DATA_W+1)'(2);
                    end
                end
            end
            OP_STORE: begin
                if (r_sp == '0) begin
                    e = ERR_STK_UNDER;
                end else if (addr_bad) begin
                    e = ERR_ADDR;
                end else begin
                    sw_we  = 1'b1;
                    sp_new = w_sp_m1;
                    top    = w_b;
                    npc    = (DATA_W+1)'(r_pc) + (DATA_W+1)'(2);
                end
            end
            OP_J: begin
                npc = target;
            end
            OP_CALL: begin
                if (r_rp == RP_W'(CALL_DEPTH)) begin
                    e = ERR_CALL_OVER;
                end else begin
                    cw_we  = 1'b1;
                    rp_new = r_rp + 1'b1;
                    npc    = target;
                end
            end
            OP_JZ, OP_JLEZ, OP_JNZ: begin
                case (r_op)
                    OP_JZ:   take = (w_a == '0);
                    OP_JLEZ: take = w_a[DATA_W-1] || (w_a == '0);
                    default: take = (w_a != '0);
                endcase
                npc = take ? target : (DATA_W+1)'(r_pc) + (DATA_W+1)'(2);
            end
            OP_RET, OP_POPC: begin
                if (r_rp == '0) begin
                    e = ERR_CALL_UNDER;
                end else begin
                    rp_new = r_rp - 1'b1;
                    if (r_op == OP_RET) begin
                        npc = (DATA_W+1)'(r_rd_ret);
                    end
                end
            end
            OP_PRINTI: pk = PK_INT;
            OP_PRINTC: pk = PK_CHAR;
            OP_POP: begin
                if (r_sp == '0) begin
                    e = ERR_STK_UNDER;
                end else begin
                    sp_new = w_sp_m1;
                    top    = w_b;
                end
            end
            OP_HALT: begin
                halt = 1'b1;
                npc  = (DATA_W+1)'(r_pc);
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE,
            OP_LT, OP_LE, OP_GT, OP_GE: begin
                if (r_sp == '0) begin
                    e = ERR_STK_UNDER;
                end else if ((r_op == OP_DIV || r_op == OP_MOD) && w_b == '0) begin
                    e = ERR_DIV_ZERO;
                end else begin
                    st_we  = 1'b1;
                    st_idx = w_sp_m1;
                    st_val = alu;
                    sp_new = w_sp_m1;
                    top    = alu;
                end
            end
            default: e = ERR_BAD_OP;
        endcase

        // Next pc must land inside program memory
        if (e == ERR_NONE && npc[DATA_W:PC_W] != '0) begin
            e = ERR_PC;
        end

        // Drop all effects of a faulting or blocked step
        if (!w_live || e != ERR_NONE) begin
            st_we  = 1'b0;
            sw_we  = 1'b0;
            cw_we  = 1'b0;
            pk     = PK_NONE;
            top    = w_a;
        end

        w_st_we  = w_commit && st_we && w_live && (e == ERR_NONE);
        w_st_idx = st_idx;
        w_st_val = st_val;
        w_sw_we  = w_commit && sw_we && w_live && (e == ERR_NONE);
        w_sw_idx = r_word[ST_W-1:0];
        w_sw_val = w_a;
        w_cw_we  = w_commit && cw_we && w_live && (e == ERR_NONE);

        n_state  = r_state;
        n_pc     = r_pc;
        n_sp     = r_sp;
        n_rp     = r_rp;
        n_halt   = r_halt;
        n_err    = r_err;
        n_hwm    = r_hwm;
        n_w0     = r_w0;
        w_res_top = r_p_top;
        w_res_pk  = r_p_pk;
        w_o_load  = 1'b0;

        case (r_state)
            S_CLEAR: begin
                if (r_clr == ST_W'(STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_state = S_COMMIT;
                end
            end
            S_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    w_o_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                if (w_div_go) begin
                    n_state = S_DIV;
                end
            end
        endcase

        // Commit the step and hand the result to the output register, or hold it pending while the output stalls
        if (w_commit) begin
            if (w_live) begin
                if (e != ERR_NONE) begin
                    n_err = e;
                end else begin
                    n_pc   = npc[PC_W-1:0];
                    n_sp   = sp_new;
                    n_rp   = rp_new;
                    n_halt = halt;
                    if (st_we && st_idx > r_hwm) begin
                        n_hwm = st_idx;
                    end
                    if (st_we && st_idx == '0) begin
                        n_w0 = 1'b1;
                    end
                end
            end
            w_res_top = top;
            w_res_pk  = pk;
            if (!r_o_valid || !i_stall) begin
                w_o_load = 1'b1;
                n_state  = S_IDLE;
            end else begin
                n_state = S_OUT;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pc    <= '0;
            r_sp    <= '0;
            r_rp    <= '0;
            r_halt  <= 1'b0;
            r_err   <= ERR_NONE;
            r_hwm   <= '0;
            r_w0    <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_sp    <= n_sp;
            r_rp    <= n_rp;
            r_halt  <= n_halt;
            r_err   <= n_err;
            r_hwm   <= n_hwm;
            r_w0    <= n_w0;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // Hold a result that cannot leave yet
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_p_top <= w_res_top;
            r_p_pk  <= w_res_pk;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= w_o_load || (r_o_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_load) begin
            r_o_pc   <= n_pc;
            r_o_top  <= w_res_top;
            r_o_pk   <= w_res_pk;
            r_o_halt <= n_halt;
            r_o_err  <= n_err;
            r_o_sp   <= n_sp;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_next_pc     = r_o_pc;
    assign o_top_value   = r_o_top;
    assign o_print_kind  = r_o_pk;
    assign o_halted      = r_o_halt;
    assign o_error_code  = r_o_err;
    assign o_stack_level = r_o_sp;

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |=> (r_err == $past(r_err)))
        else $error("sticky error changed");

    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halt || r_err != ERR_NONE) |=> ($stable(r_pc) && $stable(r_sp) && $stable(r_rp)))
        else $error("state moved after halt or error");

    a_hwm_covers_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= r_hwm)
        else $error("stack pointer above fill mark");

    a_rp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= RP_W'(CALL_DEPTH))
        else $error("return pointer out of range");

    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (o_stall && !w_st_we && !w_cw_we))
        else $error("activity during store clear");
`endif

endmodule

/* tb/stack_machine_instruction_execute_test.sv */
module stack_machine_instruction_execute_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smie_pkg::*;

    typedef struct {
        bit [PC_W-1:0]   npc;
        bit [DATA_W-1:0] top;
        bit [PK_W-1:0]   pk;
        bit              halt;
        bit [ERR_W-1:0]  err;
        bit [SP_W-1:0]   lvl;
    } t_outcome;

    typedef struct {
        bit [ERR_W-1:0]  err;
        longint          npc;
        bit              st_wr;
        int              st_idx;
        bit [DATA_W-1:0] st_val;
        bit              mem_wr;
        int              mem_idx;
        bit [DATA_W-1:0] mem_val;
        bit              call_wr;
        int              sp;
        int              cp;
        bit              halt;
        bit [PK_W-1:0]   pk;
    } t_effect;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [OP_W-1:0]          i_action;
    logic signed [DATA_W-1:0] i_operand;
    logic signed [CH_W-1:0]   i_read_char;
    logic                     o_valid;
    logic                     i_stall;
    logic [PC_W-1:0]          o_next_pc;
    logic signed [DATA_W-1:0] o_top_value;
    logic [PK_W-1:0]          o_print_kind;
    logic                     o_halted;
    logic [ERR_W-1:0]         o_error_code;
    logic [SP_W-1:0]          o_stack_level;

    stack_machine_instruction_execute dut (.*);

    // Machine state mirror
    bit [DATA_W-1:0] data_stk [0:STACK_DEPTH-1];
    bit [DATA_W-1:0] store_mem [0:STORE_DEPTH-1];
    bit [RA_W-1:0]   ret_addr [0:CALL_DEPTH-1];
    int              pc_q, sp_q, cp_q;
    bit              halt_f;
    bit [ERR_W-1:0]  err_f;

    t_outcome pending_results[$];
    int       fail_count;
    int       items_sent;
    int       results_seen;
    int       prints_seen;
    int       hold_left;
    bit       hold_start;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out what one instruction would do, without changing state
    function automatic t_effect evaluate(bit [OP_W-1:0] op, bit [DATA_W-1:0] w,
                                         bit [CH_W-1:0] rc);
        t_effect e;
        longint tgt, a, b, t;
        bit [DATA_W-1:0] top, ua, ub, r;
        bit take;
        e = '{default: 0};
        e.sp = sp_q;
        e.cp = cp_q;
        e.npc = pc_q + 1;
        tgt = longint'(signed'(w));
        top = data_stk[sp_q];
        case (op)
            OP_NOP: ;
            OP_PUSH, OP_LOAD, OP_READC: begin
                if (sp_q + 1 >= STACK_DEPTH) begin
                    e.err = ERR_STK_OVER;
                end else if (op == OP_LOAD && (tgt < 0 || tgt >= STORE_DEPTH)) begin
                    e.err = ERR_ADDR;
                end else begin
                    e.sp = sp_q + 1;
                    e.st_wr = 1;
                    e.st_idx = e.sp;
                    if (op == OP_PUSH) e.st_val = w;
                    else if (op == OP_LOAD) e.st_val = store_mem[tgt];
                    else if (rc == CH_NEWLINE) e.st_val = CH_NULL;
                    else e.st_val = DATA_W'(signed'(rc));
                    e.npc = (op == OP_READC) ? pc_q + 1 : pc_q + 2;
                end
            end
            OP_STORE: begin
                if (sp_q == 0) begin
                    e.err = ERR_STK_UNDER;
                end else if (tgt < 0 || tgt >= STORE_DEPTH) begin
                    e.err = ERR_ADDR;
                end else begin
                    e.mem_wr = 1;
                    e.mem_idx = int'(tgt);
                    e.mem_val = top;
                    e.sp = sp_q - 1;
                    e.npc = pc_q + 2;
                end
            end
            OP_J: e.npc = tgt;
            OP_CALL: begin
                if (cp_q >= CALL_DEPTH) begin
                    e.err = ERR_CALL_OVER;
                end else begin
                    e.call_wr = 1;
                    e.cp = cp_q + 1;
                    e.npc = tgt;
                end
            end
            OP_JZ, OP_JLEZ, OP_JNZ: begin
                t = longint'(signed'(top));
                if (op == OP_JZ) take = (t == 0);
                else if (op == OP_JLEZ) take = (t <= 0);
                else take = (t != 0);
                e.npc = take ? tgt : pc_q + 2;
            end
            OP_RET, OP_POPC: begin
                if (cp_q == 0) begin
                    e.err = ERR_CALL_UNDER;
                end else begin
                    e.cp = cp_q - 1;
                    if (op == OP_RET) e.npc = ret_addr[e.cp];
                end
            end
            OP_PRINTI: e.pk = PK_INT;
            OP_PRINTC: e.pk = PK_CHAR;
            OP_POP: begin
                if (sp_q == 0) e.err = ERR_STK_UNDER;
                else e.sp = sp_q - 1;
            end
            OP_HALT: begin
                e.halt = 1;
                e.npc = pc_q;
            end
            default: begin
                if (op >= OP_ADD && op <= OP_GE) begin
                    if (sp_q == 0) begin
                        e.err = ERR_STK_UNDER;
                    end else begin
                        ua = top;
                        ub = data_stk[sp_q-1];
                        a = longint'(signed'(ua));
                        b = longint'(signed'(ub));
                        if ((op == OP_DIV || op == OP_MOD) && b == 0) begin
                            e.err = ERR_DIV_ZERO;
                        end else begin
                            case (op)
                                OP_ADD: r = ua + ub;
                                OP_SUB: r = ua - ub;
                                OP_MUL: r = ua * ub;
                                OP_DIV: r = DATA_W'(a / b);
                                OP_MOD: r = DATA_W'(a % b);
                                OP_EQ:  r = DATA_W'(a == b);
                                OP_NE:  r = DATA_W'(a != b);
                                OP_LT:  r = DATA_W'(a < b);
                                OP_LE:  r = DATA_W'(a <= b);
                                OP_GT:  r = DATA_W'(a > b);
                                default: r = DATA_W'(a >= b);
                            endcase
                            e.sp = sp_q - 1;
                            e.st_wr = 1;
                            e.st_idx = e.sp;
                            e.st_val = r;
                        end
                    end
                end else begin
                    e.err = ERR_BAD_OP;
                end
            end
        endcase
        if (e.err == ERR_NONE && (e.npc < 0 || e.npc >= PROG_DEPTH)) e.err = ERR_PC;
        return e;
    endfunction

    // Execute one instruction on the mirror and return the expected result
    function automatic t_outcome execute_instr(bit [OP_W-1:0] op, bit [DATA_W-1:0] w,
                                               bit [CH_W-1:0] rc);
        t_effect e;
        t_outcome o;
        o.pk = PK_NONE;
        if (!halt_f && err_f == ERR_NONE) begin
            e = evaluate(op, w, rc);
            if (e.err != ERR_NONE) begin
                err_f = e.err;
            end else begin
                if (e.st_wr) data_stk[e.st_idx] = e.st_val;
                if (e.mem_wr) store_mem[e.mem_idx] = e.mem_val;
                if (e.call_wr) ret_addr[e.cp-1] = RA_W'(pc_q + 2);
                sp_q = e.sp;
                cp_q = e.cp;
                pc_q = int'(e.npc);
                halt_f = e.halt;
                o.pk = e.pk;
            end
        end
        o.npc = pc_q[PC_W-1:0];
        o.top = data_stk[sp_q];
        o.halt = halt_f;
        o.err = err_f;
        o.lvl = sp_q[SP_W-1:0];
        return o;
    endfunction

    // Offer one item, hold it until taken, then idle for a random gap that may be zero
    task automatic send_item(bit [OP_W-1:0] op, bit [DATA_W-1:0] w, bit [CH_W-1:0] rc);
        int r;
        int gap;
        i_valid <= 1'b1;
        i_action <= op;
        i_operand <= w;
        i_read_char <= rc;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(execute_instr(op, w, rc));
        items_sent++;
        r = $urandom_range(0, 99);
        if (r < 65) gap = 0;
        else if (r < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send only if the instruction is legal in the current state
    task automatic send_legal(bit [OP_W-1:0] op, bit [DATA_W-1:0] w, bit [CH_W-1:0] rc);
        if (evaluate(op, w, rc).err == ERR_NONE) send_item(op, w, rc);
    endtask

    // Jump home before the program counter runs off the end
    task automatic keep_pc_low();
        if (pc_q > PROG_DEPTH - 8) send_item(OP_J, '0, '0);
    endtask

    function automatic bit [DATA_W-1:0] pick_operand();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3) return $urandom_range(0, STORE_DEPTH - 1);
        if (k < 6) return $urandom_range(0, PROG_DEPTH - 1);
        if (k == 6) begin
            case ($urandom_range(0, 4))
                0: return 32'h0;
                1: return 32'h1;
                2: return 32'hFFFF_FFFF;
                3: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom;
    endfunction

    function automatic bit [OP_W-1:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return OP_PUSH;
        if (r < 30) return OP_LOAD;
        if (r < 36) return OP_STORE;
        if (r < 40) return OP_J;
        if (r < 45) return OP_CALL;
        if (r < 52) return OP_W'($urandom_range(OP_JZ, OP_JNZ));
        if (r < 57) return OP_W'($urandom_range(OP_RET, OP_POPC));
        if (r < 80) return OP_W'($urandom_range(OP_ADD, OP_GE));
        if (r < 84) return OP_W'($urandom_range(OP_PRINTI, OP_PRINTC));
        if (r < 88) return OP_READC;
        if (r < 93) return OP_POP;
        return OP_NOP;
    endfunction

    // Random legal instruction; fall back to a jump home
    task automatic send_random_legal();
        bit [OP_W-1:0] op;
        bit [DATA_W-1:0] w;
        bit [CH_W-1:0] rc;
        for (int tries = 0; tries < 50; tries++) begin
            op = pick_action();
            w = pick_operand();
            rc = CH_W'($urandom);
            if (evaluate(op, w, rc).err == ERR_NONE) begin
                send_item(op, w, rc);
                return;
            end
        end
        send_item(OP_J, '0, '0);
    endtask

    // Stop offering and wait for every expected result
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Extremes of the fields and every non-faulting operation but HALT
    task automatic test_directed();
        send_legal(OP_PUSH, 32'h7FFF_FFFF, '0);
        send_legal(OP_PUSH, 32'h1, '0);
        send_legal(OP_ADD, '0, '0);
        send_legal(OP_PUSH, 32'hFFFF_FFFF, '0);
        send_legal(OP_PUSH, 32'h8000_0000, '0);
        send_legal(OP_DIV, '0, '0);
        send_legal(OP_PUSH, 32'h2, '0);
        send_legal(OP_PUSH, 32'hFFFF_FFF9, '0);
        send_legal(OP_MOD, '0, '0);
        send_legal(OP_MUL, '0, '0);
        send_legal(OP_READC, '0, 9'h1FF);
        send_legal(OP_READC, '0, CH_NEWLINE);
        send_legal(OP_READC, '0, 9'd255);
        send_legal(OP_SUB, '0, '0);
        send_legal(OP_STORE, STORE_DEPTH - 1, '0);
        send_legal(OP_STORE, 32'h0, '0);
        send_legal(OP_LOAD, STORE_DEPTH - 1, '0);
        send_legal(OP_LOAD, 32'h0, '0);
        for (int op = OP_EQ; op <= OP_GE; op++) begin
            send_legal(OP_PUSH, $urandom_range(0, 3), '0);
            send_legal(OP_W'(op), '0, '0);
        end
        send_legal(OP_PRINTI, '0, '0);
        send_legal(OP_PRINTC, '0, '0);
        send_legal(OP_CALL, 32'd100, '0);
        send_legal(OP_RET, '0, '0);
        send_legal(OP_CALL, 32'd200, '0);
        send_legal(OP_POPC, '0, '0);
        send_legal(OP_J, PROG_DEPTH - 1, '0);
        send_legal(OP_J, 32'h0, '0);
        send_legal(OP_JZ, 32'd5, '0);
        send_legal(OP_JLEZ, 32'd9, '0);
        send_legal(OP_JNZ, 32'd13, '0);
        send_legal(OP_POP, '0, '0);
        send_legal(OP_NOP, '0, '0);
    endtask

    // Receiver holds off a long stretch while the sender keeps offering
    task automatic test_backpressure();
        hold_start = 1'b1;
        repeat (40) send_random_legal();
        wait_drained();
    endtask

    task automatic test_random(int count);
        repeat (count) send_random_legal();
    endtask

    // Trigger one fault or a halt, then check that nothing executes afterward
    task automatic test_terminal_fault(int kind);
        case (kind)
            0: send_item(OP_HALT, $urandom, CH_W'($urandom));
            ERR_BAD_OP: send_item(OP_W'($urandom_range(OP_HALT + 1, 31)), $urandom,
                                  CH_W'($urandom));
            ERR_STK_UNDER: begin
                while (sp_q > 0) begin
                    keep_pc_low();
                    send_item(OP_POP, '0, '0);
                end
                send_item(OP_W'($urandom_range(OP_ADD, OP_GE)), '0, '0);
            end
            ERR_CALL_OVER: begin
                while (cp_q < CALL_DEPTH) send_item(OP_CALL, pc_q, '0);
                send_item(OP_CALL, pc_q, '0);
            end
            ERR_CALL_UNDER: begin
                while (cp_q > 0) begin
                    keep_pc_low();
                    send_item(OP_POPC, '0, '0);
                end
                send_item(OP_RET, '0, '0);
            end
            ERR_DIV_ZERO: begin
                while (sp_q > STACK_DEPTH - 8) send_item(OP_POP, '0, '0);
                keep_pc_low();
                send_item(OP_PUSH, '0, '0);
                send_item(OP_PUSH, $urandom, '0);
                send_item(OP_W'($urandom_range(OP_DIV, OP_MOD)), '0, '0);
            end
            ERR_ADDR: begin
                while (sp_q > STACK_DEPTH - 8) send_item(OP_POP, '0, '0);
                send_item(OP_LOAD, $urandom_range(0, 1) ? 32'hFFFF_FFFF : STORE_DEPTH, '0);
            end
            default: send_item(OP_J, $urandom_range(0, 1) ? 32'h8000_0000 : PROG_DEPTH, '0);
        endcase
        repeat (6) send_item(OP_W'($urandom), $urandom, CH_W'($urandom));
    endtask

    // Receiver stall: random stalls and short hold-offs plus one long hold-off on request
    always @(posedge i_clk) begin
        int r;
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) hold_left = $urandom_range(10, 40);
            i_stall <= (r < 25);
        end
    end

    function automatic void compare_field(string name, bit [31:0] exp_v, bit [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Check each taken result against the oldest expectation
    always @(posedge i_clk) begin
        t_outcome x;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no expected item pending");
                fail_count++;
            end else begin
                x = pending_results.pop_front();
                results_seen++;
                if (x.pk != PK_NONE) prints_seen++;
                compare_field("next_pc", x.npc, o_next_pc);
                compare_field("top_value", x.top, o_top_value);
                compare_field("print_kind", x.pk, o_print_kind);
                compare_field("halted", x.halt, o_halted);
                compare_field("error_code", x.err, o_error_code);
                compare_field("stack_level", x.lvl, o_stack_level);
            end
        end
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int kind;
        int n_rand;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = '0;
        i_operand = '0;
        i_read_char = '0;
        i_stall = 1'b0;
        hold_start = 1'b0;
        hold_left = 0;
        pc_q = 0;
        sp_q = 0;
        cp_q = 0;
        halt_f = 1'b0;
        err_f = ERR_NONE;
        foreach (data_stk[i]) data_stk[i] = '0;
        foreach (store_mem[i]) store_mem[i] = '0;

        // Pick the closing fault now so the random phases fit the item budget
        kind = $urandom_range(0, 7);
        if (kind >= ERR_STK_OVER) kind++;
        n_rand = (kind == ERR_CALL_OVER) ? 400 : 650;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(n_rand);
        test_backpressure();
        test_random(n_rand);
        test_terminal_fault(kind);

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        $display("Ran %0d instructions, checked %0d results (%0d print requests).",
                 items_sent, results_seen, prints_seen);
        $display("Final state: pc %0d, stack level %0d, halted %0d, error %0d.",
                 pc_q, sp_q, halt_f, err_f);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/smie_pkg.sv
design/smie_divider.sv
design/stack_machine_instruction_execute.sv
tb/stack_machine_instruction_execute_test.sv
